/* hw/rtl/fqa_pkg.sv */
`timescale 1ns / 1ps

package fqa_pkg;

    // Width of the x and y samples, and number of CORDIC rotations.
    localparam int IN_WIDTH   = 16;
    localparam int ITERATIONS = 16;

    // Magnitudes are placed so that their top bit lands at bit 59.
    localparam int PRESHIFT = 60 - IN_WIDTH;
    // Rotated vector: up to about 2.33 * 2^59, plus a sign bit.
    localparam int CW = 62;

    // Angle accumulator, signed, 28 fraction bits.
    localparam int ANG_FRAC = 28;
    localparam int ZW       = 32;
    // First-quadrant angle after clamping, and full-circle angle, both unsigned.
    localparam int AW = 29;
    localparam int FW = 31;

    localparam int OUT_W     = 16;
    localparam int OUT_SHIFT = ANG_FRAC - 13;

    localparam logic [AW-1:0] HALF_PI_Q28 = AW'(421657428);
    localparam logic [FW-1:0] PI_Q28      = FW'(843314857);
    localparam logic [FW-1:0] TWO_PI_Q28  = FW'(1686629713);

    localparam logic [OUT_SHIFT+1:0] ANGLE_FULL = (OUT_SHIFT + 2)'(51472);

    localparam logic [OUT_W-1:0] ANGLE_ZERO     = OUT_W'(0);
    localparam logic [OUT_W-1:0] ANGLE_HALF_PI  = OUT_W'(12868);
    localparam logic [OUT_W-1:0] ANGLE_PI       = OUT_W'(25736);
    localparam logic [OUT_W-1:0] ANGLE_3HALF_PI = OUT_W'(38604);

    // How the final angle is formed: a fixed axis angle or a quadrant mapping.
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_POS_Y,
        SEL_NEG_X,
        SEL_NEG_Y,
        SEL_Q1,
        SEL_Q2,
        SEL_Q3,
        SEL_Q4
    } sel_t;

    // One item as it moves through the rotation pipeline.
    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        sel_t                 sel;
    } cordic_t;

    // Rounded arctangent of 2^-i in Q.28.
    function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
        logic signed [ZW-1:0] step;
        case (i)
            0:       step = ZW'(210828714);
            1:       step = ZW'(124459457);
            2:       step = ZW'(65760959);
            3:       step = ZW'(33381290);
            4:       step = ZW'(16755422);
            5:       step = ZW'(8385879);
            6:       step = ZW'(4193963);
            7:       step = ZW'(2097109);
            8:       step = ZW'(1048571);
            9:       step = ZW'(524287);
            default: step = (i <= ANG_FRAC) ? ZW'(64'(1) << (ANG_FRAC - i)) : '0;
        endcase
        return step;
    endfunction

endpackage

/* hw/rtl/fqa_prep.sv */
`timescale 1ns / 1ps

module fqa_prep (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [fqa_pkg::IN_WIDTH-1:0]   x_value,
    input  logic signed [fqa_pkg::IN_WIDTH-1:0]   y_value,
    output logic                                  out_valid,
    output fqa_pkg::cordic_t                      out_item
);

    logic                        x_neg;
    logic                        y_neg;
    logic                        x_zero;
    logic                        y_zero;
    logic [fqa_pkg::IN_WIDTH-1:0] ax;
    logic [fqa_pkg::IN_WIDTH-1:0] ay;
    fqa_pkg::sel_t               sel;
    fqa_pkg::cordic_t            item_next;
    fqa_pkg::cordic_t            item_reg;
    logic                        valid_reg;

    assign x_neg  = x_value[fqa_pkg::IN_WIDTH-1];
    assign y_neg  = y_value[fqa_pkg::IN_WIDTH-1];
    assign x_zero = (x_value == '0);
    assign y_zero = (y_value == '0);

    // The magnitude of the most negative sample still fits as an unsigned value.
    assign ax = x_neg ? (~x_value + 1'b1) : x_value;
    assign ay = y_neg ? (~y_value + 1'b1) : y_value;

    always_comb
    begin
        if (x_zero && y_zero)
            sel = fqa_pkg::SEL_ZERO;
        else if (y_zero && !x_neg)
            sel = fqa_pkg::SEL_ZERO;
        else if (x_zero && !y_neg)
            sel = fqa_pkg::SEL_POS_Y;
        else if (y_zero)
            sel = fqa_pkg::SEL_NEG_X;
        else if (x_zero)
            sel = fqa_pkg::SEL_NEG_Y;
        else if (!x_neg && !y_neg)
            sel = fqa_pkg::SEL_Q1;
        else if (x_neg && !y_neg)
            sel = fqa_pkg::SEL_Q2;
        else if (x_neg)
            sel = fqa_pkg::SEL_Q3;
        else
            sel = fqa_pkg::SEL_Q4;
    end

    always_comb
    begin
        item_next.cx  = {2'b00, ax, {fqa_pkg::PRESHIFT{1'b0}}};
        item_next.cy  = {2'b00, ay, {fqa_pkg::PRESHIFT{1'b0}}};
        item_next.z   = '0;
        item_next.sel = sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* hw/rtl/fqa_cordic.sv */
`timescale 1ns / 1ps

module fqa_cordic (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  fqa_pkg::cordic_t in_item,
    output logic             out_valid,
    output fqa_pkg::cordic_t out_item
);

    localparam int N = fqa_pkg::ITERATIONS;

    fqa_pkg::cordic_t src_w [N+1];
    logic [N:0]       vld_w;
    fqa_pkg::cordic_t stage_next [N];
    fqa_pkg::cordic_t stage_reg [N];
    logic [N-1:0]     valid_reg;

    assign src_w[0] = in_item;
    assign vld_w[0] = in_valid;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic signed [fqa_pkg::CW-1:0] dx;
        logic signed [fqa_pkg::CW-1:0] dy;
        logic signed [fqa_pkg::ZW-1:0] step;

        assign dx   = src_w[k].cy >>> k;
        assign dy   = src_w[k].cx >>> k;
        assign step = fqa_pkg::atan_step(k);

        // Rotate toward the x axis; the sign of y picks the direction.
        always_comb
        begin
            stage_next[k] = src_w[k];
            if (!src_w[k].cy[fqa_pkg::CW-1])
            begin
                stage_next[k].cx = src_w[k].cx + dx;
                stage_next[k].cy = src_w[k].cy - dy;
                stage_next[k].z  = src_w[k].z + step;
            end
            else
            begin
                stage_next[k].cx = src_w[k].cx - dx;
                stage_next[k].cy = src_w[k].cy + dy;
                stage_next[k].z  = src_w[k].z - step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stage_reg[k] <= stage_next[k];
        end

        assign src_w[k+1] = stage_reg[k];
        assign vld_w[k+1] = valid_reg[k];
    end

    assign out_valid = vld_w[N];
    assign out_item  = src_w[N];

endmodule

/* hw/rtl/fqa_post.sv */
`timescale 1ns / 1ps

module fqa_post (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  fqa_pkg::cordic_t              in_item,
    output logic                          out_valid,
    output logic [fqa_pkg::OUT_W-1:0]     angle
);

    localparam int RW = fqa_pkg::FW - fqa_pkg::OUT_SHIFT + 1;

    logic [fqa_pkg::AW-1:0]       a_clamp;
    logic [fqa_pkg::FW-1:0]       a_ext;
    logic [fqa_pkg::FW-1:0]       full_next;
    logic [fqa_pkg::FW-1:0]       full_reg;
    fqa_pkg::sel_t                sel_reg;
    logic                         map_valid_reg;
    logic [fqa_pkg::FW:0]         rounded_sum;
    logic [RW-1:0]                rounded;
    logic [fqa_pkg::OUT_W-1:0]    angle_next;
    logic [fqa_pkg::OUT_W-1:0]    angle_reg;
    logic                         valid_reg;

    // Stage one: clamp the first-quadrant angle and map it to its quadrant.
    always_comb
    begin
        if (in_item.z[fqa_pkg::ZW-1])
            a_clamp = '0;
        else if (in_item.z > $signed({1'b0, {(fqa_pkg::ZW-fqa_pkg::AW-1){1'b0}},
                                      fqa_pkg::HALF_PI_Q28}))
            a_clamp = fqa_pkg::HALF_PI_Q28;
        else
            a_clamp = in_item.z[fqa_pkg::AW-1:0];
    end

    assign a_ext = {{(fqa_pkg::FW-fqa_pkg::AW){1'b0}}, a_clamp};

    always_comb
    begin
        case (in_item.sel)
            fqa_pkg::SEL_Q2: full_next = fqa_pkg::PI_Q28 - a_ext;
            fqa_pkg::SEL_Q3: full_next = fqa_pkg::PI_Q28 + a_ext;
            fqa_pkg::SEL_Q4: full_next = fqa_pkg::TWO_PI_Q28 - a_ext;
            default:         full_next = a_ext;
        endcase
    end

    // Stage two: round half up to 13 fraction bits and fold 2*pi back to zero.
    assign rounded_sum = {1'b0, full_reg} + (fqa_pkg::FW + 1)'(1 << (fqa_pkg::OUT_SHIFT - 1));
    assign rounded     = rounded_sum[fqa_pkg::FW:fqa_pkg::OUT_SHIFT];

    always_comb
    begin
        case (sel_reg)
            fqa_pkg::SEL_ZERO:  angle_next = fqa_pkg::ANGLE_ZERO;
            fqa_pkg::SEL_POS_Y: angle_next = fqa_pkg::ANGLE_HALF_PI;
            fqa_pkg::SEL_NEG_X: angle_next = fqa_pkg::ANGLE_PI;
            fqa_pkg::SEL_NEG_Y: angle_next = fqa_pkg::ANGLE_3HALF_PI;
            default:
            begin
                if (rounded >= RW'(fqa_pkg::ANGLE_FULL))
                    angle_next = fqa_pkg::ANGLE_ZERO;
                else
                    angle_next = rounded[fqa_pkg::OUT_W-1:0];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            map_valid_reg <= in_valid;
            valid_reg     <= map_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            full_reg  <= full_next;
            sel_reg   <= in_item.sel;
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg;
    assign angle     = angle_reg;

endmodule

/* hw/rtl/four_quadrant_arctangent.sv */
`timescale 1ns / 1ps

// Four-quadrant arctangent: each input beat carries a signed (x_value, y_value) pair and
// produces one output beat with angle = atan2(y, x) in [0, 2*pi), as unsigned Q3.13 radians
// rounded to nearest, where 2*pi itself wraps to 0. Vectors on an axis give exactly 0, pi/2,
// pi or 3*pi/2, and the origin gives 0. The block is a fully pipelined CORDIC in vectoring
// mode: one input register that folds the vector into the first quadrant and classifies
// it, one register stage per CORDIC rotation (16 of them), then a stage that clamps and maps
// the angle to its quadrant and a stage that rounds into the output register. It accepts one
// beat per clock as long as the output is not stalled. A stall on the output freezes the whole
// pipeline, so in_stall follows out_stall while an output beat is waiting, and nothing is lost
// or repeated. There is no state between items and no configuration.

module four_quadrant_arctangent (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fqa_pkg::IN_WIDTH-1:0] x_value,
    input  logic signed [fqa_pkg::IN_WIDTH-1:0] y_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [fqa_pkg::OUT_W-1:0]           angle
);

    logic             en;
    logic             prep_valid;
    fqa_pkg::cordic_t prep_item;
    logic             rot_valid;
    fqa_pkg::cordic_t rot_item;

    // The pipeline advances unless a finished beat sits in the output register unclaimed.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    fqa_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .x_value   (x_value),
        .y_value   (y_value),
        .out_valid (prep_valid),
        .out_item  (prep_item)
    );

    fqa_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prep_valid),
        .in_item   (prep_item),
        .out_valid (rot_valid),
        .out_item  (rot_item)
    );

    fqa_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_item   (rot_item),
        .out_valid (out_valid),
        .angle     (angle)
    );

endmodule

/* hw/rtl/fqa_checker.sv */
`timescale 1ns / 1ps

module fqa_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic signed [fqa_pkg::IN_WIDTH-1:0] x_value,
    input logic signed [fqa_pkg::IN_WIDTH-1:0] y_value,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [fqa_pkg::OUT_W-1:0]           angle
);

    // A stalled input beat holds its payload until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(x_value) && $stable(y_value))
        else $error("input beat changed while stalled");

    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle))
        else $error("output beat changed while stalled");

    // Every angle stays below 2*pi.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> angle < 16'd51472)
        else $error("angle at or above 2*pi");

    // A waiting output beat holds back the input side.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output beat is stalled");

    // With no output beat waiting, the input is never stalled.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with an empty output");

endmodule

bind four_quadrant_arctangent fqa_checker u_fqa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_value   (x_value),
    .y_value   (y_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .angle     (angle)
);
